/* rtl/nal_split_pkg.sv */
// Shared types and constants for the Annex B NAL splitter.
package nal_split_pkg;

  localparam int unsigned DataW    = 8;
  localparam int unsigned TypeW    = 5;
  localparam int unsigned NalSizeW = 24;
  // Results one byte can cause: up to four zeros and a record, or three zeros, the byte and a record.
  localparam int unsigned ResCntW  = 3;
  localparam int unsigned ZeroCntW = 2;

  localparam logic [TypeW-1:0] TypeMask = 5'h1f;
  localparam logic [TypeW-1:0] IdrType  = 5'd5;
  localparam logic [DataW-1:0] ScByte   = 8'h01;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_RECORD  = 1'b1
  } kind_e;

endpackage

/* rtl/h264_annexb_nal_splitter.sv */
// Annex B byte stream splitter: NAL payload bytes and end-of-NAL records.
//
//   channel | signals                                    | direction
//   --------+--------------------------------------------+----------
//   in      | in_valid_i in_ready_o data_i last_i        | request in
//   out     | out_valid_o out_ready_i kind_o payload_o   | request out
//           | unit_len_o unit_type_o keyframe_o run_end_o |
//
// One stream byte is taken per cycle while each byte yields at most one result and the output
// does not stall. A byte that yields n results (n is 1 to 5) stays in the item register until
// the single output register has taken all n, one result per cycle while it is not stalled.
// Bytes that yield no result (held zeros, bytes before the first start code) leave without
// using the output register. Reset clears the parser state and both valid flags; no clearing
// pass follows. An output stall holds the output register and, through it, the item register.
module h264_annexb_nal_splitter #(
  parameter int unsigned SIZE_BITS = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [nal_split_pkg::DataW-1:0]  data_i,
  input  logic                             last_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             kind_o,
  output logic [nal_split_pkg::DataW-1:0]  payload_o,
  output logic [nal_split_pkg::NalSizeW-1:0] unit_len_o,
  output logic [nal_split_pkg::TypeW-1:0]  unit_type_o,
  output logic                             keyframe_o,
  output logic                             run_end_o
);
  import nal_split_pkg::*;

  localparam int unsigned ExtW = (SIZE_BITS > NalSizeW) ? SIZE_BITS : NalSizeW;

  // Item register
  logic               item_valid_q, item_valid_d;
  logic [DataW-1:0]   data_q, data_d;
  logic               last_q, last_d;
  logic [ResCntW-1:0] idx_q, idx_d;

  // Parser state
  logic [ZeroCntW-1:0]  pz_q, pz_d;
  logic                 inside_q, inside_d;
  logic [SIZE_BITS-1:0] cnt_q, cnt_d;
  logic [TypeW-1:0]     type_q, type_d;
  logic                 taken_q, taken_d;
  logic                 idr_q, idr_d;

  // Output register
  logic               out_valid_q, out_valid_d;
  logic               kind_q, kind_d;
  logic [DataW-1:0]   payload_q, payload_d;
  logic [NalSizeW-1:0] size_q, size_d;
  logic [TypeW-1:0]   ntype_q, ntype_d;
  logic               key_q, key_d;
  logic               rend_q, rend_d;

  // Plan for the held byte
  logic                 is_zero, is_sc, has_byte;
  logic [ResCntW-1:0]   zpre, zpost, zcnt, pay_n, res_n;
  logic [ZeroCntW-1:0]  pz_mid;
  logic [SIZE_BITS:0]   cnt_sum;
  logic [SIZE_BITS-1:0] cnt_fin;
  logic [TypeW-1:0]     first_type, type_fin;
  logic                 take_now, taken_fin, idr_fin;
  logic                 is_rec, run_end;
  logic [SIZE_BITS-1:0] rec_cnt;
  logic [ExtW-1:0]      rec_cnt_ext;
  logic                 out_load, emit, item_done;

  always_comb begin
    is_zero  = (data_q == '0);
    is_sc    = (data_q == ScByte) && (pz_q >= ZeroCntW'(2)) && !last_q;
    zpre     = '0;
    has_byte = 1'b0;
    pz_mid   = '0;
    if (is_zero) begin
      // a fourth zero pushes the oldest held one out
      if (pz_q == ZeroCntW'(3)) begin
        zpre   = ResCntW'(1);
        pz_mid = pz_q;
      end else begin
        pz_mid = pz_q + ZeroCntW'(1);
      end
    end else if (!is_sc) begin
      zpre     = ResCntW'(pz_q);
      has_byte = 1'b1;
    end
    zpost = last_q ? ResCntW'(pz_mid) : '0;
    zcnt  = zpre + zpost;
    pay_n = inside_q ? (zcnt + ResCntW'(has_byte)) : '0;
    if (!inside_q) begin
      res_n = '0;
    end else if (is_sc) begin
      res_n = ResCntW'(1);
    end else begin
      res_n = pay_n + ResCntW'(last_q);
    end

    // saturating count after this byte's payload
    cnt_sum = {1'b0, cnt_q} + (SIZE_BITS+1)'(pay_n);
    cnt_fin = cnt_sum[SIZE_BITS] ? '1 : cnt_sum[SIZE_BITS-1:0];

    first_type = (zcnt != '0) ? '0 : (data_q[TypeW-1:0] & TypeMask);
    take_now   = !taken_q && (pay_n != '0);
    type_fin   = take_now ? first_type : type_q;
    taken_fin  = taken_q | take_now;
    idr_fin    = idr_q | (take_now && (first_type == IdrType));

    // result at position idx_q
    is_rec      = is_sc || (idx_q >= pay_n);
    run_end     = ((idx_q + ResCntW'(1)) == res_n);
    rec_cnt     = is_sc ? cnt_q : cnt_fin;
    rec_cnt_ext = ExtW'(rec_cnt);

    out_load  = !out_valid_q || out_ready_i;
    emit      = item_valid_q && (res_n != '0) && out_load;
    item_done = item_valid_q && ((res_n == '0) || (emit && run_end));
  end

  assign in_ready_o = !item_valid_q || item_done;

  always_comb begin
    item_valid_d = item_valid_q;
    data_d       = data_q;
    last_d       = last_q;
    idx_d        = idx_q;
    if (item_done) begin
      item_valid_d = 1'b0;
      idx_d        = '0;
    end else if (emit) begin
      idx_d = idx_q + ResCntW'(1);
    end
    if (in_valid_i && in_ready_o) begin
      item_valid_d = 1'b1;
      data_d       = data_i;
      last_d       = last_i;
    end
  end

  always_comb begin
    pz_d     = pz_q;
    inside_d = inside_q;
    cnt_d    = cnt_q;
    type_d   = type_q;
    taken_d  = taken_q;
    idr_d    = idr_q;
    if (item_done) begin
      if (last_q) begin
        // end of buffer: back to the reset state
        pz_d     = '0;
        inside_d = 1'b0;
        cnt_d    = '0;
        type_d   = '0;
        taken_d  = 1'b0;
        idr_d    = 1'b0;
      end else if (is_sc) begin
        // open a new NAL
        pz_d     = '0;
        inside_d = 1'b1;
        cnt_d    = '0;
        type_d   = '0;
        taken_d  = 1'b0;
      end else begin
        pz_d    = pz_mid;
        cnt_d   = inside_q ? cnt_fin : cnt_q;
        type_d  = type_fin;
        taken_d = taken_fin;
        idr_d   = idr_fin;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    payload_d   = payload_q;
    size_d      = size_q;
    ntype_d     = ntype_q;
    key_d       = key_q;
    rend_d      = rend_q;
    if (out_load) begin
      out_valid_d = emit;
      rend_d      = run_end;
      if (is_rec) begin
        kind_d    = KIND_RECORD;
        payload_d = '0;
        size_d    = rec_cnt_ext[NalSizeW-1:0];
        ntype_d   = is_sc ? (taken_q ? type_q : '0) : (taken_fin ? type_fin : '0);
        key_d     = is_sc ? idr_q : idr_fin;
      end else begin
        kind_d    = KIND_PAYLOAD;
        payload_d = (has_byte && (idx_q == zcnt)) ? data_q : '0;
        size_d    = '0;
        ntype_d   = '0;
        key_d     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      idx_q        <= '0;
      pz_q         <= '0;
      inside_q     <= 1'b0;
      cnt_q        <= '0;
      type_q       <= '0;
      taken_q      <= 1'b0;
      idr_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      idx_q        <= idx_d;
      pz_q         <= pz_d;
      inside_q     <= inside_d;
      cnt_q        <= cnt_d;
      type_q       <= type_d;
      taken_q      <= taken_d;
      idr_q        <= idr_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q    <= data_d;
    last_q    <= last_d;
    kind_q    <= kind_d;
    payload_q <= payload_d;
    size_q    <= size_d;
    ntype_q   <= ntype_d;
    key_q     <= key_d;
    rend_q    <= rend_d;
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign payload_o   = payload_q;
  assign unit_len_o  = size_q;
  assign unit_type_o = ntype_q;
  assign keyframe_o  = key_q;
  assign run_end_o   = rend_q;

endmodule
